// ===== rtl/cbcp_pkg.sv =====
package cbcp_pkg;

    // storage sizes
    localparam int MAX_CLASSES = 16;
    localparam int MAX_CHILD   = 256;
    localparam int ID_WIDTH    = 32;

    // fixed field widths
    localparam int CLS_W      = 4;
    localparam int CNT_W      = 9;
    localparam int NCLS_W     = 5;
    localparam int PORT_ID_W  = 32;
    localparam int CHILD_SZ_W = 9;
    localparam int CFG_W      = 9;

    // derived widths
    localparam int CLS_IDX_W  = $clog2(MAX_CLASSES);
    localparam int ADDR_W     = $clog2(MAX_CHILD);
    localparam int SIZE_W     = $clog2(MAX_CHILD + 1);

    // configuration register indexes
    localparam logic REG_CLASS_QUOTA = 1'b0;
    localparam logic REG_NUM_CLASSES = 1'b1;

    // item codes
    localparam logic OP_PAIR  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic             clear;
        logic             inc;
        logic [CLS_W-1:0] cls;
    } t_cls_ctrl;

    typedef struct packed {
        logic eligible;
        logic complete;
    } t_cls_stat;

    typedef struct packed {
        logic start;
        logic wr_en;
    } t_scan_ctrl;

    typedef struct packed {
        logic done;
        logic hit;
    } t_scan_stat;

endpackage

// ===== rtl/cbcp_class_tab.sv =====
module cbcp_class_tab (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cbcp_pkg::t_cls_ctrl           i_ctrl,
    input  logic [cbcp_pkg::CNT_W-1:0]    i_quota,
    input  logic [cbcp_pkg::NCLS_W-1:0]   i_eff_classes,
    output cbcp_pkg::t_cls_stat           o_stat
);
    import cbcp_pkg::*;

    logic [CNT_W-1:0]     r_count [MAX_CLASSES];
    logic [CLS_IDX_W-1:0] cls_idx;
    logic                 cls_in_use;
    logic                 all_done;

    assign cls_idx    = CLS_IDX_W'(i_ctrl.cls);
    assign cls_in_use = (NCLS_W'(i_ctrl.cls) < i_eff_classes);

    // per-class counters, cleared together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            for (int i = 0; i < MAX_CLASSES; i++) begin
                r_count[i] <= '0;
            end
        end else if (i_ctrl.inc) begin
            r_count[cls_idx] <= r_count[cls_idx] + CNT_W'(1);
        end
    end

    // every class in use sitting exactly at quota
    always_comb begin
        all_done = 1'b1;
        for (int i = 0; i < MAX_CLASSES; i++) begin
            if ((i < int'(i_eff_classes)) && (r_count[i] != i_quota)) begin
                all_done = 1'b0;
            end
        end
    end

    assign o_stat.eligible = cls_in_use && (r_count[cls_idx] < i_quota);
    assign o_stat.complete = all_done;

endmodule

// ===== rtl/cbcp_id_scan.sv =====
module cbcp_id_scan (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cbcp_pkg::t_scan_ctrl           i_ctrl,
    input  logic [cbcp_pkg::ID_WIDTH-1:0]  i_key,
    input  logic [cbcp_pkg::SIZE_W-1:0]    i_count,
    output cbcp_pkg::t_scan_stat           o_stat
);
    import cbcp_pkg::*;

    logic [ID_WIDTH-1:0] r_mem [MAX_CHILD];
    logic [ID_WIDTH-1:0] r_rd_data;
    logic [SIZE_W-1:0]   r_addr;
    logic                r_pend;
    logic                r_active;
    logic                match;
    logic                done;
    logic                issue;

    assign match = r_pend && (r_rd_data == i_key);
    assign done  = r_active && (match || ((r_addr == i_count) && !r_pend));
    assign issue = r_active && !done && (r_addr < i_count);

    // id store, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_count[ADDR_W-1:0]] <= i_key;
        end
        r_rd_data <= r_mem[r_addr[ADDR_W-1:0]];
    end

    // linear walk over the written entries, one compare a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pend   <= 1'b0;
            r_addr   <= '0;
        end else if (i_ctrl.start) begin
            r_active <= 1'b1;
            r_pend   <= 1'b0;
            r_addr   <= '0;
        end else begin
            if (done) begin
                r_active <= 1'b0;
            end
            r_pend <= issue;
            if (issue) begin
                r_addr <= r_addr + SIZE_W'(1);
            end
        end
    end

    assign o_stat.done = done;
    assign o_stat.hit  = match;

endmodule

// ===== rtl/class_balanced_crossover_picker.sv =====
// class-balanced crossover picker: one transaction is either a clear or a
// candidate pair (one entry from each parent, an id and a class each, plus a
// bit saying which entry is tried first). an entry goes into the child set
// when its class is in use, its class count is below quota, the id store is
// not full and its id is not already stored; otherwise the other entry is
// tried. every transaction gives exactly one result, shown for a single cycle
// on the result ports with o_valid high; there is no way to hold it off, so
// the receiver must take it in that cycle. busy is high from the cycle after
// start is taken until the result cycle, and start is only looked at while
// busy is low (a new start may coincide with the result cycle). a clear goes
// from idle straight to the result state. a pair is checked on class, quota
// and room in the store, one entry at a time; an entry that passes goes into
// the id search, which walks the stored ids one entry per cycle through the
// store's single read port, with one comparator shared by both entries. the
// store needs no clearing pass, as only entries below the fill count are
// ever read.
// configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once
// and must only be issued while no transaction is in flight.
module class_balanced_crossover_picker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [cbcp_pkg::CFG_W-1:0]        i_cfg_data,
    // transaction in
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_op,
    input  logic [cbcp_pkg::PORT_ID_W-1:0]    i_first_id,
    input  logic [cbcp_pkg::CLS_W-1:0]        i_first_class,
    input  logic [cbcp_pkg::PORT_ID_W-1:0]    i_second_id,
    input  logic [cbcp_pkg::CLS_W-1:0]        i_second_class,
    input  logic                              i_prefer_first,
    // result
    output logic                              o_valid,
    output logic                              o_accepted,
    output logic                              o_from_second,
    output logic [cbcp_pkg::PORT_ID_W-1:0]    o_out_id,
    output logic [cbcp_pkg::CLS_W-1:0]        o_out_class,
    output logic                              o_child_complete,
    output logic [cbcp_pkg::CHILD_SZ_W-1:0]   o_child_size
);
    import cbcp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ELIG,
        S_SCAN,
        S_DONE
    } t_state;

    t_state              r_state;

    // configuration registers
    logic [CNT_W-1:0]    r_class_quota;
    logic [NCLS_W-1:0]   r_num_classes;
    logic [NCLS_W-1:0]   eff_classes;

    // fill count of the id store, also the child size
    logic [SIZE_W-1:0]   r_stored_count;

    // entry under test and the one held back
    logic [ID_WIDTH-1:0] r_cand_id;
    logic [CLS_W-1:0]    r_cand_cls;
    logic                r_cand_sec;
    logic [ID_WIDTH-1:0] r_alt_id;
    logic [CLS_W-1:0]    r_alt_cls;
    logic                r_alt_sec;
    logic                r_on_alt;

    // result being built
    logic                r_acc;
    logic                r_sec;
    logic [ID_WIDTH-1:0] r_res_id;
    logic [CLS_W-1:0]    r_res_cls;

    logic                start_acc;
    logic                cand_ok;
    logic                take;
    logic                store_full;

    t_cls_ctrl           cls_ctrl;
    t_cls_stat           cls_stat;
    t_scan_ctrl          scan_ctrl;
    t_scan_stat          scan_stat;

    // classes beyond the table are never in use
    assign eff_classes = (int'(r_num_classes) > MAX_CLASSES) ? NCLS_W'(MAX_CLASSES)
                                                             : r_num_classes;

    assign busy       = (r_state != S_IDLE);
    assign start_acc  = start && !busy;
    assign store_full = (r_stored_count >= SIZE_W'(MAX_CHILD));

    // class and quota test plus room in the store, ahead of the id search
    assign cand_ok = cls_stat.eligible && !store_full;
    // search finished without a duplicate: commit the entry
    assign take    = (r_state == S_SCAN) && scan_stat.done && !scan_stat.hit;

    assign cls_ctrl.clear  = start_acc && (i_op == OP_CLEAR);
    assign cls_ctrl.inc    = take;
    assign cls_ctrl.cls    = r_cand_cls;

    assign scan_ctrl.start = (r_state == S_ELIG) && cand_ok;
    assign scan_ctrl.wr_en = take;

    cbcp_class_tab u_class_tab (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (cls_ctrl),
        .i_quota       (r_class_quota),
        .i_eff_classes (eff_classes),
        .o_stat        (cls_stat)
    );

    cbcp_id_scan u_id_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (scan_ctrl),
        .i_key   (r_cand_id),
        .i_count (r_stored_count),
        .o_stat  (scan_stat)
    );

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_quota <= CNT_W'(1);
            r_num_classes <= NCLS_W'(2);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CLASS_QUOTA: r_class_quota <= i_cfg_data[CNT_W-1:0];
                REG_NUM_CLASSES: r_num_classes <= i_cfg_data[NCLS_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, fill count and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_stored_count <= '0;
            o_valid        <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start_acc) begin
                        r_acc     <= 1'b0;
                        r_sec     <= 1'b0;
                        r_res_id  <= '0;
                        r_res_cls <= '0;
                        r_on_alt  <= 1'b0;
                        // order the pair by the preference bit
                        if (i_prefer_first) begin
                            r_cand_id  <= ID_WIDTH'(i_first_id);
                            r_cand_cls <= i_first_class;
                            r_cand_sec <= 1'b0;
                            r_alt_id   <= ID_WIDTH'(i_second_id);
                            r_alt_cls  <= i_second_class;
                            r_alt_sec  <= 1'b1;
                        end else begin
                            r_cand_id  <= ID_WIDTH'(i_second_id);
                            r_cand_cls <= i_second_class;
                            r_cand_sec <= 1'b1;
                            r_alt_id   <= ID_WIDTH'(i_first_id);
                            r_alt_cls  <= i_first_class;
                            r_alt_sec  <= 1'b0;
                        end
                        if (i_op == OP_CLEAR) begin
                            r_stored_count <= '0;
                            r_state        <= S_DONE;
                        end else begin
                            r_state <= S_ELIG;
                        end
                    end
                end
                S_ELIG: begin
                    if (cand_ok) begin
                        r_state <= S_SCAN;
                    end else if (!r_on_alt) begin
                        r_cand_id  <= r_alt_id;
                        r_cand_cls <= r_alt_cls;
                        r_cand_sec <= r_alt_sec;
                        r_on_alt   <= 1'b1;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SCAN: begin
                    if (take) begin
                        r_acc          <= 1'b1;
                        r_sec          <= r_cand_sec;
                        r_res_id       <= r_cand_id;
                        r_res_cls      <= r_cand_cls;
                        r_stored_count <= r_stored_count + SIZE_W'(1);
                        r_state        <= S_DONE;
                    end else if (scan_stat.done) begin
                        // duplicate id: fall back to the other entry
                        if (!r_on_alt) begin
                            r_cand_id  <= r_alt_id;
                            r_cand_cls <= r_alt_cls;
                            r_cand_sec <= r_alt_sec;
                            r_on_alt   <= 1'b1;
                            r_state    <= S_ELIG;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    // counters already reflect this transaction here
                    o_valid          <= 1'b1;
                    o_accepted       <= r_acc;
                    o_from_second    <= r_sec;
                    o_out_id         <= PORT_ID_W'(r_res_id);
                    o_out_class      <= r_res_cls;
                    o_child_complete <= cls_stat.complete;
                    o_child_size     <= CHILD_SZ_W'(r_stored_count);
                    r_state          <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // a result is only ever shown with the sequencer back at rest
    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while a transaction is in flight");

    // nothing is written into a full id store
    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> !store_full)
        else $error("id store written beyond its depth");

    // a taken entry always belongs to a class in use
    a_taken_class_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> (NCLS_W'(r_cand_cls) < eff_classes))
        else $error("entry taken from a class not in use");

    // a refused pair reports an empty entry
    a_refused_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_accepted) |-> (o_out_id == '0 && o_out_class == '0 && !o_from_second))
        else $error("refused pair reports entry fields");

    // the child grows by one exactly when an entry is taken
    a_size_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && $past(i_rst_n)) |=> (r_stored_count == $past(r_stored_count) + SIZE_W'(1)))
        else $error("child size out of step with taken entries");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import cbcp_pkg::*;

    // a pair scan walks up to MAX_CHILD stored ids for each of two entries;
    // this gives ample room for that plus a long sender gap
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 20;

    // one candidate pair or clear, as it goes into the block
    typedef struct packed {
        logic                 op;
        logic [PORT_ID_W-1:0] a_id;
        logic [CLS_W-1:0]     a_cls;
        logic [PORT_ID_W-1:0] b_id;
        logic [CLS_W-1:0]     b_cls;
        logic                 pref_a;
    } t_pair_item;

    // one result of the block
    typedef struct packed {
        logic                  taken;
        logic                  from_b;
        logic [PORT_ID_W-1:0]  id;
        logic [CLS_W-1:0]      cls;
        logic                  complete;
        logic [CHILD_SZ_W-1:0] size;
    } t_pick;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    // one line of the directed stimulus table
    typedef struct {
        t_row_kind      kind;
        t_pair_item     item;
        logic           reg_idx;
        logic [CFG_W-1:0] reg_val;
        bit             has_want;
        t_pick          want;
    } t_dir_row;

    // configuration phases of the random part
    typedef struct {
        logic [CFG_W-1:0]  quota;
        logic [NCLS_W-1:0] ncls;
        int                n_items;
    } t_phase;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic                  i_cfg_idx;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  start;
    logic                  busy;
    logic                  i_op;
    logic [PORT_ID_W-1:0]  i_first_id;
    logic [CLS_W-1:0]      i_first_class;
    logic [PORT_ID_W-1:0]  i_second_id;
    logic [CLS_W-1:0]      i_second_class;
    logic                  i_prefer_first;
    logic                  o_valid;
    logic                  o_accepted;
    logic                  o_from_second;
    logic [PORT_ID_W-1:0]  o_out_id;
    logic [CLS_W-1:0]      o_out_class;
    logic                  o_child_complete;
    logic [CHILD_SZ_W-1:0] o_child_size;

    class_balanced_crossover_picker dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_first_id       (i_first_id),
        .i_first_class    (i_first_class),
        .i_second_id      (i_second_id),
        .i_second_class   (i_second_class),
        .i_prefer_first   (i_prefer_first),
        .o_valid          (o_valid),
        .o_accepted       (o_accepted),
        .o_from_second    (o_from_second),
        .o_out_id         (o_out_id),
        .o_out_class      (o_out_class),
        .o_child_complete (o_child_complete),
        .o_child_size     (o_child_size)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor state: its own copy of the counters, the id store and the
    // two registers
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]     class_tally [MAX_CLASSES];
    logic [PORT_ID_W-1:0] child_ids   [MAX_CHILD];
    int                   child_fill;
    logic [CFG_W-1:0]     quota_reg;
    logic [NCLS_W-1:0]    ncls_reg;

    t_pick pending_picks [$];   // expected results, oldest first

    // run statistics
    int mismatches;
    int results_seen;
    int n_items;
    int n_clears;
    int n_taken;
    int n_complete;
    int full_refusals;
    int n_reg_writes;
    int idle_pct;
    int stall_cycles;

    // classes actually in use: the register may exceed the class count
    function automatic int classes_live();
        return (ncls_reg > MAX_CLASSES) ? MAX_CLASSES : int'(ncls_reg);
    endfunction

    // try to put one entry into the child set; order of the checks matters,
    // a full store is only noticed once the id search has missed
    function automatic bit try_insert(logic [PORT_ID_W-1:0] id, logic [CLS_W-1:0] cls);
        if (cls >= classes_live())
            return 1'b0;
        if (class_tally[cls] >= quota_reg)
            return 1'b0;
        for (int i = 0; i < child_fill; i++)
            if (child_ids[i] == id)
                return 1'b0;
        if (child_fill >= MAX_CHILD) begin
            full_refusals++;
            return 1'b0;
        end
        child_ids[child_fill] = id;
        child_fill++;
        class_tally[cls]++;
        return 1'b1;
    endfunction

    // work out the result of one transaction and move the state on
    function automatic t_pick predict_pick(t_pair_item it);
        t_pick res;
        res = '0;
        if (it.op == OP_CLEAR) begin
            foreach (class_tally[c])
                class_tally[c] = '0;
            child_fill = 0;
        end else if (it.pref_a) begin
            if (try_insert(it.a_id, it.a_cls))
                res = '{taken: 1'b1, from_b: 1'b0, id: it.a_id, cls: it.a_cls, default: '0};
            else if (try_insert(it.b_id, it.b_cls))
                res = '{taken: 1'b1, from_b: 1'b1, id: it.b_id, cls: it.b_cls, default: '0};
        end else begin
            if (try_insert(it.b_id, it.b_cls))
                res = '{taken: 1'b1, from_b: 1'b1, id: it.b_id, cls: it.b_cls, default: '0};
            else if (try_insert(it.a_id, it.a_cls))
                res = '{taken: 1'b1, from_b: 1'b0, id: it.a_id, cls: it.a_cls, default: '0};
        end
        // complete when every class in use sits exactly on the quota
        res.complete = 1'b1;
        for (int c = 0; c < classes_live(); c++)
            if (class_tally[c] != quota_reg)
                res.complete = 1'b0;
        res.size = CHILD_SZ_W'(child_fill);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // present one transaction, with a random gap before it, and hold it until
    // the block takes it; start is left high so back-to-back transactions
    // never see it dropped and raised in the same step
    task automatic send_item(input t_pair_item it, input bit has_want, input t_pick want);
        t_pick p;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_op           <= it.op;
        i_first_id     <= it.a_id;
        i_first_class  <= it.a_cls;
        i_second_id    <= it.b_id;
        i_second_class <= it.b_cls;
        i_prefer_first <= it.pref_a;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        // transaction taken at this edge
        p = predict_pick(it);
        pending_picks.push_back(has_want ? want : p);
        n_items++;
        if (it.op == OP_CLEAR)
            n_clears++;
        if (p.taken)
            n_taken++;
        if (p.complete)
            n_complete++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_picks.size() != 0)
            @(posedge i_clk);
    endtask

    // register write, only ever with the block idle
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        settle();
        repeat (2) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_CLASS_QUOTA)
            quota_reg = val;
        else
            ncls_reg = val[NCLS_W-1:0];
        n_reg_writes++;
    endtask

    // random transaction: mostly pairs drawn from a small id pool so that
    // duplicates come up, with classes mostly in use; a few clears and some
    // fully random pairs as noise
    function automatic t_pair_item make_item(logic [PORT_ID_W-1:0] pool_base);
        t_pair_item it;
        int         live;
        int         roll;
        live = classes_live();
        roll = $urandom_range(0, 99);
        it.a_id   = $urandom;
        it.b_id   = $urandom;
        it.a_cls  = CLS_W'($urandom_range(0, 15));
        it.b_cls  = CLS_W'($urandom_range(0, 15));
        it.pref_a = 1'($urandom_range(0, 1));
        it.op     = OP_PAIR;
        if (roll < 4) begin
            it.op = OP_CLEAR;
        end else if (roll >= 12) begin
            it.a_id = pool_base + PORT_ID_W'($urandom_range(0, 63));
            it.b_id = pool_base + PORT_ID_W'($urandom_range(0, 63));
            if (live > 0 && $urandom_range(0, 99) < 85)
                it.a_cls = CLS_W'($urandom_range(0, live - 1));
            if (live > 0 && $urandom_range(0, 99) < 85)
                it.b_cls = CLS_W'($urandom_range(0, live - 1));
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // directed table helpers
    // ------------------------------------------------------------------
    function automatic t_dir_row pair_row(logic [PORT_ID_W-1:0] aid, logic [CLS_W-1:0] acls,
                                          logic [PORT_ID_W-1:0] bid, logic [CLS_W-1:0] bcls,
                                          logic pref);
        t_dir_row r;
        r.kind     = ROW_ITEM;
        r.item     = '{op: OP_PAIR, a_id: aid, a_cls: acls, b_id: bid, b_cls: bcls,
                       pref_a: pref};
        r.reg_idx  = REG_CLASS_QUOTA;
        r.reg_val  = '0;
        r.has_want = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    // clears carry all-ones in the pair fields, which must be ignored
    function automatic t_dir_row clear_row();
        t_dir_row r;
        r         = pair_row('1, '1, '1, '1, 1'b1);
        r.item.op = OP_CLEAR;
        return r;
    endfunction

    function automatic t_dir_row reg_row(logic idx, logic [CFG_W-1:0] val);
        t_dir_row r;
        r         = pair_row('0, '0, '0, '0, 1'b0);
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_dir_row typed(t_dir_row r, logic acc, logic fb,
                                       logic [PORT_ID_W-1:0] id, logic [CLS_W-1:0] cls,
                                       logic cmp, logic [CHILD_SZ_W-1:0] size);
        r.has_want = 1'b1;
        r.want     = '{taken: acc, from_b: fb, id: id, cls: cls, complete: cmp, size: size};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checker: every strobe is compared with the oldest expectation
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pick want;
        if (i_rst_n && o_valid) begin
            if (pending_picks.size() == 0) begin
                $display("%0t: result with no transaction outstanding", $time);
                mismatches++;
            end else begin
                want = pending_picks.pop_front();
                check_field("accepted",       32'(want.taken),    32'(o_accepted));
                check_field("from_second",    32'(want.from_b),   32'(o_from_second));
                check_field("out_id",         32'(want.id),       32'(o_out_id));
                check_field("out_class",      32'(want.cls),      32'(o_out_class));
                check_field("child_complete", 32'(want.complete), 32'(o_child_complete));
                check_field("child_size",     32'(want.size),     32'(o_child_size));
                results_seen++;
            end
        end
    end

    // watchdog: cycles with neither a transaction taken nor a result shown
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        t_dir_row         dir_tab [$];
        t_phase           phases  [$];
        t_pair_item       it;
        logic [PORT_ID_W-1:0] pool_base;
        logic [PORT_ID_W-1:0] fill_base;
        int               idle_steps [3];

        // all inputs known from time zero
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= REG_CLASS_QUOTA;
        i_cfg_data     <= '0;
        start          <= 1'b0;
        i_op           <= OP_PAIR;
        i_first_id     <= '0;
        i_first_class  <= '0;
        i_second_id    <= '0;
        i_second_class <= '0;
        i_prefer_first <= 1'b0;

        // predictor in its reset state
        quota_reg  = CFG_W'(1);
        ncls_reg   = NCLS_W'(2);
        child_fill = 0;
        foreach (class_tally[c])
            class_tally[c] = '0;
        foreach (child_ids[k])
            child_ids[k] = '0;
        mismatches    = 0;
        results_seen  = 0;
        n_items       = 0;
        n_clears      = 0;
        n_taken       = 0;
        n_complete    = 0;
        full_refusals = 0;
        n_reg_writes  = 0;
        idle_pct      = 0;
        idle_steps    = '{0, 73, 16};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: reset values first (quota 1, two classes), then
        // the corner cases; results typed in where obvious
        dir_tab = '{
            // first entry taken after reset, class 15 out of range
            typed(pair_row(32'h0, 4'd0, 32'hFFFF_FFFF, 4'd15, 1'b1), 1, 0, 0, 0, 0, 1),
            // second entry class out of range, first at quota: nothing taken
            typed(pair_row(32'h0, 4'd0, 32'hFFFF_FFFF, 4'd15, 1'b0), 0, 0, 0, 0, 0, 1),
            // duplicate id refused, fall back to parent b
            typed(pair_row(32'h0, 4'd1, 32'h5, 4'd1, 1'b1), 1, 1, 5, 1, 1, 2),
            // both classes at quota
            typed(pair_row(32'hAAAA_AAAA, 4'd0, 32'h5555_5555, 4'd1, 1'b0), 0, 0, 0, 0, 1, 2),
            typed(clear_row(), 0, 0, 0, 0, 0, 0),
            // quota zero: nothing taken, child counts as complete
            reg_row(REG_CLASS_QUOTA, 9'd0),
            typed(pair_row(32'h7, 4'd0, 32'h8, 4'd1, 1'b1), 0, 0, 0, 0, 1, 0),
            typed(clear_row(), 0, 0, 0, 0, 1, 0),
            // no classes in use
            reg_row(REG_NUM_CLASSES, 9'd0),
            reg_row(REG_CLASS_QUOTA, 9'd3),
            typed(pair_row(32'h9, 4'd0, 32'hA, 4'd0, 1'b1), 0, 0, 0, 0, 1, 0),
            // class count beyond the maximum, upper data bits set; top quota
            reg_row(REG_NUM_CLASSES, 9'h1FF),
            reg_row(REG_CLASS_QUOTA, 9'h100),
            pair_row(32'h1, 4'd3, 32'hFFFF_FFFF, 4'd15, 1'b0),
            pair_row(32'hFFFF_FFFF, 4'd15, 32'h1234_5678, 4'd15, 1'b1),
            pair_row(32'h0, 4'd15, 32'h0, 4'd15, 1'b0),
            // quota lowered below a count: complete stays low until a clear
            reg_row(REG_NUM_CLASSES, 9'd16),
            reg_row(REG_CLASS_QUOTA, 9'd2),
            typed(clear_row(), 0, 0, 0, 0, 0, 0),
            pair_row(32'h100, 4'd3, 32'h101, 4'd3, 1'b1),
            pair_row(32'h101, 4'd3, 32'h102, 4'd4, 1'b1),
            pair_row(32'h103, 4'd3, 32'h104, 4'd3, 1'b0),
            reg_row(REG_CLASS_QUOTA, 9'd1),
            pair_row(32'h105, 4'd0, 32'h106, 4'd3, 1'b1),
            clear_row()
        };

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_REG)
                write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            else
                send_item(dir_tab[i].item, dir_tab[i].has_want, dir_tab[i].want);
        end

        // random part: one phase per setting, extremes included, idling
        // pattern rotated per phase
        phases = '{
            '{quota: 9'd1,   ncls: 5'd1,  n_items: 100},
            '{quota: 9'd2,   ncls: 5'd2,  n_items: 90},
            '{quota: 9'd3,   ncls: 5'd4,  n_items: 100},
            '{quota: 9'd256, ncls: 5'd16, n_items: 100},
            '{quota: 9'd5,   ncls: 5'd31, n_items: 90},
            '{quota: 9'd0,   ncls: 5'd7,  n_items: 50},
            '{quota: 9'd1,   ncls: 5'd16, n_items: 100},
            '{quota: 9'd4,   ncls: 5'd0,  n_items: 40},
            '{quota: 9'd9,   ncls: 5'd3,  n_items: 100},
            '{quota: 9'd200, ncls: 5'd2,  n_items: 60},
            '{quota: 9'd7,   ncls: 5'd5,  n_items: 60}
        };

        foreach (phases[p]) begin
            write_reg(REG_CLASS_QUOTA, phases[p].quota);
            // upper data bits random, only the low five count
            write_reg(REG_NUM_CLASSES, {4'($urandom_range(0, 15)), phases[p].ncls});
            idle_pct  = idle_steps[p % 3];
            pool_base = $urandom;
            // each phase opens a fresh child set
            it = '{op: OP_CLEAR, a_id: $urandom, a_cls: '0, b_id: $urandom, b_cls: '0,
                   pref_a: 1'b0};
            send_item(it, 1'b0, '0);
            for (int n = 0; n < phases[p].n_items; n++) begin
                // now and then hold back until the block has drained
                if ($urandom_range(0, 39) == 0)
                    settle();
                send_item(make_item(pool_base), 1'b0, '0);
            end
        end

        // fill the id store to capacity with unique ids over two classes,
        // then keep offering new and repeated ids against the full store
        write_reg(REG_CLASS_QUOTA, 9'd256);
        write_reg(REG_NUM_CLASSES, 9'd2);
        idle_pct  = 16;
        fill_base = $urandom;
        it = '{op: OP_CLEAR, a_id: '0, a_cls: '0, b_id: '0, b_cls: '0, pref_a: 1'b0};
        send_item(it, 1'b0, '0);
        for (int n = 0; n < MAX_CHILD + 40; n++) begin
            it.op     = OP_PAIR;
            it.a_id   = fill_base + PORT_ID_W'(2 * n);
            it.b_id   = fill_base + PORT_ID_W'(2 * n + 1);
            it.a_cls  = CLS_W'($urandom_range(0, 1));
            it.b_cls  = CLS_W'($urandom_range(0, 15));
            it.pref_a = 1'($urandom_range(0, 1));
            if (n >= MAX_CHILD && $urandom_range(0, 2) == 0)
                it.a_id = fill_base + PORT_ID_W'(2 * $urandom_range(0, MAX_CHILD - 1));
            send_item(it, 1'b0, '0);
        end

        // drain, then keep watching for any stray strobe
        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run: %0d transactions (%0d clears), %0d results checked, %0d entries taken",
                 n_items, n_clears, results_seen, n_taken);
        $display("run: %0d register writes, %0d complete results, %0d full-store refusals",
                 n_reg_writes, n_complete, full_refusals);
        if (mismatches == 0 && pending_picks.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
